@@ src/morse_element_timing_decoder_defines.svh @@
// Assertion macros for the decoder top level.
`ifndef MORSE_ELEMENT_TIMING_DECODER_DEFINES_SVH
`define MORSE_ELEMENT_TIMING_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define METD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// Checked on every edge, reset included.
`define METD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define METD_ASSERT(lbl, prop, msg)
`define METD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/metd_pkg.sv @@
package metd_pkg;

    localparam int PATTERN_CAPACITY = 8;
    localparam int WORD_CAPACITY    = 32;

    // The pattern register keeps at most seven elements.
    localparam int PAT_MAX  = (PATTERN_CAPACITY - 1 < 7) ? PATTERN_CAPACITY - 1 : 7;
    localparam int WORD_MAX = WORD_CAPACITY - 1;
    localparam int WCNT_W   = $clog2(WORD_CAPACITY);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAINING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIT_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_MULT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_MULT = 3'd4;

    localparam logic [15:0] DIT_LEN_RESET   = 16'd60;
    localparam logic [3:0]  CHAR_MULT_RESET = 4'd3;
    localparam logic [3:0]  WORD_MULT_RESET = 4'd7;

    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;

    localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;

    typedef struct packed {
        logic        enable;
        logic        training;
        logic [15:0] dit_len;
        logic [3:0]  char_mult;
        logic [3:0]  word_mult;
        logic        clear;
    } cfg_t;

    typedef struct packed {
        logic              has_char;
        logic              has_word;
        logic [1:0]        kind;
        logic [6:0]        char_code;
        logic [6:0]        bits;
        logic [2:0]        len;
        logic [31:0]       end_time;
        logic [WCNT_W-1:0] word_len;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } bk_state_t;

    // Key is {length, pattern}; bit i of the pattern is element i, 1 for dah.
    function automatic logic [6:0] decode_pattern(input logic [6:0] bits,
                                                  input logic [2:0] len);
        logic [9:0] key;
        logic [6:0] ch;
        key = {len, bits};
        unique case (key)
            {3'd2, 7'd2}:  ch = 7'("A");
            {3'd4, 7'd1}:  ch = 7'("B");
            {3'd4, 7'd5}:  ch = 7'("C");
            {3'd3, 7'd1}:  ch = 7'("D");
            {3'd1, 7'd0}:  ch = 7'("E");
            {3'd4, 7'd4}:  ch = 7'("F");
            {3'd3, 7'd3}:  ch = 7'("G");
            {3'd4, 7'd0}:  ch = 7'("H");
            {3'd2, 7'd0}:  ch = 7'("I");
            {3'd4, 7'd14}: ch = 7'("J");
            {3'd3, 7'd5}:  ch = 7'("K");
            {3'd4, 7'd2}:  ch = 7'("L");
            {3'd2, 7'd3}:  ch = 7'("M");
            {3'd2, 7'd1}:  ch = 7'("N");
            {3'd3, 7'd7}:  ch = 7'("O");
            {3'd4, 7'd6}:  ch = 7'("P");
            {3'd4, 7'd11}: ch = 7'("Q");
            {3'd3, 7'd2}:  ch = 7'("R");
            {3'd3, 7'd0}:  ch = 7'("S");
            {3'd1, 7'd1}:  ch = 7'("T");
            {3'd3, 7'd4}:  ch = 7'("U");
            {3'd4, 7'd8}:  ch = 7'("V");
            {3'd3, 7'd6}:  ch = 7'("W");
            {3'd4, 7'd9}:  ch = 7'("X");
            {3'd4, 7'd13}: ch = 7'("Y");
            {3'd4, 7'd3}:  ch = 7'("Z");
            {3'd5, 7'd31}: ch = 7'("0");
            {3'd5, 7'd30}: ch = 7'("1");
            {3'd5, 7'd28}: ch = 7'("2");
            {3'd5, 7'd24}: ch = 7'("3");
            {3'd5, 7'd16}: ch = 7'("4");
            {3'd5, 7'd0}:  ch = 7'("5");
            {3'd5, 7'd1}:  ch = 7'("6");
            {3'd5, 7'd3}:  ch = 7'("7");
            {3'd5, 7'd7}:  ch = 7'("8");
            {3'd5, 7'd15}: ch = 7'("9");
            {3'd6, 7'd42}: ch = 7'(".");
            {3'd6, 7'd51}: ch = 7'(",");
            {3'd6, 7'd12}: ch = 7'("?");
            {3'd5, 7'd9}:  ch = 7'("/");
            {3'd5, 7'd17}: ch = 7'("=");
            {3'd5, 7'd10}: ch = 7'("+");
            {3'd6, 7'd33}: ch = 7'("-");
            default:       ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

@@ src/morse_element_timing_decoder.sv @@
// Channel  | Ports                                              | Handshake
// input    | s_op s_is_dah s_time_ms s_tx_active                | s_valid / s_ready
// result   | m_kind m_char_code m_pattern_bits m_pattern_len    | m_valid / m_ready
//          | m_end_time_ms m_last                               |
// config   | cfg_index cfg_wr_data                              | cfg_wr_en, no wait
//
// A character result passes through a two-entry command queue to the output register.
// Each stored word character is fetched through the word RAM's registered read.
// s_ready is low while the queue is full, and from a tick that closes a word until the
// word's last character has been loaded into the output register.
// Reset is synchronous and needs no clearing pass; the word RAM is read only below the count.
`include "morse_element_timing_decoder_defines.svh"

module morse_element_timing_decoder
    import metd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic                  s_is_dah,
    input  logic [31:0]           s_time_ms,
    input  logic                  s_tx_active,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [6:0]            m_char_code,
    output logic [6:0]            m_pattern_bits,
    output logic [2:0]            m_pattern_len,
    output logic [31:0]           m_end_time_ms,
    output logic                  m_last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic        enable_reg;
    logic        training_reg;
    logic [15:0] dit_len_reg;
    logic [3:0]  char_mult_reg;
    logic [3:0]  word_mult_reg;
    cfg_t        cfg;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    cmd_t              q_in;
    cmd_t              q_head;
    logic              ram_wr_en;
    logic [WCNT_W-1:0] ram_wr_addr;
    logic [6:0]        ram_wr_data;
    logic [WCNT_W-1:0] ram_rd_addr;
    logic [6:0]        ram_rd_data;
    logic              word_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            training_reg  <= 1'b0;
            dit_len_reg   <= DIT_LEN_RESET;
            char_mult_reg <= CHAR_MULT_RESET;
            word_mult_reg <= WORD_MULT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:    enable_reg    <= cfg_wr_data[0];
                REG_TRAINING:  training_reg  <= cfg_wr_data[0];
                REG_DIT_LEN:   dit_len_reg   <= cfg_wr_data;
                REG_CHAR_MULT: char_mult_reg <= cfg_wr_data[3:0];
                REG_WORD_MULT: word_mult_reg <= cfg_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.enable    = enable_reg;
    assign cfg.training  = training_reg;
    assign cfg.dit_len   = dit_len_reg;
    assign cfg.char_mult = char_mult_reg;
    assign cfg.word_mult = word_mult_reg;
    assign cfg.clear     = cfg_wr_en && (cfg_index == REG_ENABLE) && !cfg_wr_data[0];

    metd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_is_dah    (s_is_dah),
        .s_time_ms   (s_time_ms),
        .s_tx_active (s_tx_active),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_in),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .word_done   (word_done)
    );

    metd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    metd_ram #(
        .WIDTH (7),
        .DEPTH (WORD_CAPACITY)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    metd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_cmd          (q_head),
        .q_pop          (q_pop),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .word_done      (word_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_char_code    (m_char_code),
        .m_pattern_bits (m_pattern_bits),
        .m_pattern_len  (m_pattern_len),
        .m_end_time_ms  (m_end_time_ms),
        .m_last         (m_last)
    );

    `METD_ASSERT(a_queue_no_overflow, q_push |-> !q_full, "command queue overflow")
    `METD_ASSERT(a_word_end_marked, word_done |=> m_valid && m_last && (m_kind == KIND_WORD), "word end not marked")
    `METD_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid && q_empty, "reset left results behind")

endmodule

@@ src/metd_ram.sv @@
module metd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/metd_fifo.sv @@
module metd_fifo
    import metd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/metd_front.sv @@
module metd_front
    import metd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic              s_is_dah,
    input  logic [31:0]       s_time_ms,
    input  logic              s_tx_active,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd,
    output logic              ram_wr_en,
    output logic [WCNT_W-1:0] ram_wr_addr,
    output logic [6:0]        ram_wr_data,
    input  logic              word_done
);

    logic [6:0]        pat_bits_reg, pat_bits_next;
    logic [2:0]        pat_len_reg, pat_len_next;
    logic              pending_reg, pending_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic [WCNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic              word_busy_reg, word_busy_next;

    logic              accept;
    logic              is_elem;
    logic              is_tick;
    logic [31:0]       silence;
    logic [19:0]       char_thr;
    logic [19:0]       word_thr;
    logic              char_hit;
    logic              word_hit;
    logic              store_ch;
    logic [WCNT_W-1:0] word_cnt_after;
    logic [6:0]        ch;

    // While a stored word is being sent, the word store must not be refilled.
    assign s_ready = !q_full && !word_busy_reg;
    assign accept  = s_valid && s_ready;
    assign is_elem = accept && cfg.enable && (s_op == OP_ELEMENT);
    assign is_tick = accept && cfg.enable && (s_op == OP_TICK) && !s_tx_active;

    assign silence  = s_time_ms - last_time_reg;
    assign char_thr = {4'd0, cfg.dit_len} * {16'd0, cfg.char_mult};
    assign word_thr = {4'd0, cfg.dit_len} * {16'd0, cfg.word_mult};
    assign ch       = decode_pattern(pat_bits_reg, pat_len_reg);

    assign char_hit = is_tick && pending_reg && (silence >= {12'd0, char_thr});
    assign store_ch = char_hit && !cfg.training && (word_cnt_reg < WCNT_W'(WORD_MAX));
    assign word_cnt_after = store_ch ? word_cnt_reg + WCNT_W'(1) : word_cnt_reg;
    // A word closes only once no character is left pending after this tick.
    assign word_hit = is_tick && (char_hit || !pending_reg) && (word_cnt_after != '0)
                      && (silence >= {12'd0, word_thr});

    assign q_push             = char_hit || word_hit;
    assign q_cmd.has_char     = char_hit;
    assign q_cmd.has_word     = word_hit;
    assign q_cmd.kind         = cfg.training ? KIND_TRAIN : KIND_CHAR;
    assign q_cmd.char_code    = ch;
    assign q_cmd.bits         = pat_bits_reg;
    assign q_cmd.len          = pat_len_reg;
    assign q_cmd.end_time     = last_time_reg;
    assign q_cmd.word_len     = word_cnt_after;

    assign ram_wr_en   = store_ch;
    assign ram_wr_addr = word_cnt_reg;
    assign ram_wr_data = ch;

    always_comb begin
        pat_bits_next  = pat_bits_reg;
        pat_len_next   = pat_len_reg;
        pending_next   = pending_reg;
        last_time_next = last_time_reg;
        word_cnt_next  = word_cnt_reg;
        word_busy_next = word_busy_reg;
        priority if (cfg.clear) begin
            pat_bits_next = '0;
            pat_len_next  = '0;
            pending_next  = 1'b0;
            word_cnt_next = '0;
        end else if (is_elem) begin
            // Elements beyond capacity are dropped but still mark the time.
            if (pat_len_reg < 3'(PAT_MAX)) begin
                pat_bits_next = pat_bits_reg | (7'(s_is_dah) << pat_len_reg);
                pat_len_next  = pat_len_reg + 3'd1;
            end
            last_time_next = s_time_ms;
            pending_next   = 1'b1;
        end else if (is_tick) begin
            if (char_hit) begin
                pat_bits_next = '0;
                pat_len_next  = '0;
                pending_next  = 1'b0;
            end
            word_cnt_next = word_hit ? '0 : word_cnt_after;
        end
        if (word_done) begin
            word_busy_next = 1'b0;
        end else if (word_hit) begin
            word_busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bits_reg  <= '0;
            pat_len_reg   <= '0;
            pending_reg   <= 1'b0;
            last_time_reg <= '0;
            word_cnt_reg  <= '0;
            word_busy_reg <= 1'b0;
        end else begin
            pat_bits_reg  <= pat_bits_next;
            pat_len_reg   <= pat_len_next;
            pending_reg   <= pending_next;
            last_time_reg <= last_time_next;
            word_cnt_reg  <= word_cnt_next;
            word_busy_reg <= word_busy_next;
        end
    end

endmodule

@@ src/metd_back.sv @@
module metd_back
    import metd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic [WCNT_W-1:0] ram_rd_addr,
    input  logic [6:0]        ram_rd_data,
    output logic              word_done,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [6:0]        m_char_code,
    output logic [6:0]        m_pattern_bits,
    output logic [2:0]        m_pattern_len,
    output logic [31:0]       m_end_time_ms,
    output logic              m_last
);

    bk_state_t         state_reg, state_next;
    logic [WCNT_W-1:0] idx_reg, idx_next;
    logic [WCNT_W-1:0] wlen_reg, wlen_next;
    logic [31:0]       wtime_reg, wtime_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_kind_reg;
    logic [6:0]        m_char_code_reg;
    logic [6:0]        m_pattern_bits_reg;
    logic [2:0]        m_pattern_len_reg;
    logic [31:0]       m_end_time_reg;
    logic              m_last_reg;

    logic              out_free;
    logic              load_char;
    logic              load_word;
    logic              last_word;

    assign out_free    = !m_valid_reg || m_ready;
    assign last_word   = ((idx_reg + WCNT_W'(1)) == wlen_reg);
    assign ram_rd_addr = idx_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty && out_free && q_cmd.has_word) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                state_next = BK_SEND;
            end
            BK_SEND: begin
                if (out_free) begin
                    state_next = last_word ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        load_char = 1'b0;
        load_word = 1'b0;
        word_done = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop     = !q_empty && out_free;
                load_char = q_pop && q_cmd.has_char;
            end
            BK_READ: begin
            end
            BK_SEND: begin
                load_word = out_free;
                word_done = out_free && last_word;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        wlen_next  = wlen_reg;
        wtime_next = wtime_reg;
        if (q_pop && q_cmd.has_word) begin
            idx_next   = '0;
            wlen_next  = q_cmd.word_len;
            wtime_next = q_cmd.end_time;
        end else if (load_word) begin
            idx_next = idx_reg + WCNT_W'(1);
        end
        if (load_char || load_word) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        wlen_reg  <= wlen_next;
        wtime_reg <= wtime_next;
        if (load_char) begin
            m_kind_reg         <= q_cmd.kind;
            m_char_code_reg    <= q_cmd.char_code;
            m_pattern_bits_reg <= q_cmd.bits;
            m_pattern_len_reg  <= q_cmd.len;
            m_end_time_reg     <= q_cmd.end_time;
            // The character is not the final result when a word follows it.
            m_last_reg         <= !q_cmd.has_word;
        end else if (load_word) begin
            m_kind_reg         <= KIND_WORD;
            m_char_code_reg    <= ram_rd_data;
            m_pattern_bits_reg <= '0;
            m_pattern_len_reg  <= '0;
            m_end_time_reg     <= wtime_reg;
            m_last_reg         <= last_word;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_char_code    = m_char_code_reg;
    assign m_pattern_bits = m_pattern_bits_reg;
    assign m_pattern_len  = m_pattern_len_reg;
    assign m_end_time_ms  = m_end_time_reg;
    assign m_last         = m_last_reg;

endmodule

@@ test/morse_element_timing_decoder_tb.sv @@
module morse_element_timing_decoder_tb;
    import metd_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int ITU_ENTRIES   = 43;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  code;
        logic [6:0]  bits;
        logic [2:0]  len;
        logic [31:0] end_time;
        logic        last;
    } char_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_op        = OP_ELEMENT;
    logic                  s_is_dah    = 1'b0;
    logic [31:0]           s_time_ms   = '0;
    logic                  s_tx_active = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_kind;
    logic [6:0]            m_char_code;
    logic [6:0]            m_pattern_bits;
    logic [2:0]            m_pattern_len;
    logic [31:0]           m_end_time_ms;
    logic                  m_last;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    morse_element_timing_decoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_is_dah       (s_is_dah),
        .s_time_ms      (s_time_ms),
        .s_tx_active    (s_tx_active),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_char_code    (m_char_code),
        .m_pattern_bits (m_pattern_bits),
        .m_pattern_len  (m_pattern_len),
        .m_end_time_ms  (m_end_time_ms),
        .m_last         (m_last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // Decoder state mirrored by the testbench.
    logic        cfg_enable;
    logic        cfg_training;
    logic [15:0] cfg_dit;
    logic [3:0]  cfg_char_mult;
    logic [3:0]  cfg_word_mult;
    logic [6:0]  pat_bits;
    int          pat_len;
    bit          char_open;
    logic [31:0] last_end;
    logic [6:0]  word_chars [WORD_CAPACITY];
    int          word_len;

    char_result_t expected_chars[$];

    string itu_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?/=+-";
    string itu_codes [ITU_ENTRIES] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-.-.-", "--..--", "..--..", "-..-.", "-...-", ".-.-.", "-....-"
    };

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    bit          hold_toggle   = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          mismatches    = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          reg_writes    = 0;
    logic [31:0] cur_time      = '0;

    function automatic logic [6:0] code_to_bits(string code);
        logic [6:0] b;
        b = '0;
        for (int n = 0; n < code.len() && n < 7; n++)
            if (code[n] == "-") b[n] = 1'b1;
        return b;
    endfunction

    function automatic logic [6:0] lookup_char(logic [6:0] bits, int len);
        for (int e = 0; e < ITU_ENTRIES; e++)
            if (itu_codes[e].len() == len && code_to_bits(itu_codes[e]) == bits)
                return 7'(itu_chars[e]);
        return CHAR_UNKNOWN;
    endfunction

    function automatic void clear_decoder_state();
        pat_bits  = '0;
        pat_len   = 0;
        char_open = 1'b0;
        word_len  = 0;
    endfunction

    function automatic void reset_decoder_state();
        cfg_enable    = 1'b1;
        cfg_training  = 1'b0;
        cfg_dit       = DIT_LEN_RESET;
        cfg_char_mult = CHAR_MULT_RESET;
        cfg_word_mult = WORD_MULT_RESET;
        last_end      = '0;
        clear_decoder_state();
    endfunction

    // Works out the results one accepted input transaction causes.
    task automatic decode_item(input logic op, input logic dah, input logic [31:0] t,
                               input logic tx);
        logic [31:0]  silence;
        char_result_t closed;
        char_result_t wc;
        bit           have_char;
        have_char = 1'b0;
        if (!cfg_enable) return;
        if (op == OP_ELEMENT) begin
            // Elements past the capacity are dropped but still move the end time.
            if (pat_len < PAT_MAX) begin
                pat_bits[pat_len] = dah;
                pat_len++;
            end
            last_end  = t;
            char_open = 1'b1;
            return;
        end
        if (tx) return;
        silence = t - last_end;
        if (char_open && silence >= 32'(cfg_dit) * 32'(cfg_char_mult)) begin
            closed.kind     = cfg_training ? KIND_TRAIN : KIND_CHAR;
            closed.code     = lookup_char(pat_bits, pat_len);
            closed.bits     = pat_bits;
            closed.len      = 3'(pat_len);
            closed.end_time = last_end;
            closed.last     = 1'b1;
            have_char       = 1'b1;
            if (!cfg_training && word_len < WORD_MAX) begin
                word_chars[word_len] = closed.code;
                word_len++;
            end
            pat_bits  = '0;
            pat_len   = 0;
            char_open = 1'b0;
        end
        if (!char_open && word_len > 0 && silence >= 32'(cfg_dit) * 32'(cfg_word_mult)) begin
            if (have_char) begin
                closed.last = 1'b0;
                expected_chars.push_back(closed);
            end
            for (int i = 0; i < word_len; i++) begin
                wc.kind     = KIND_WORD;
                wc.code     = word_chars[i];
                wc.bits     = '0;
                wc.len      = '0;
                wc.end_time = last_end;
                wc.last     = (i == word_len - 1);
                expected_chars.push_back(wc);
            end
            word_len = 0;
        end else if (have_char) begin
            expected_chars.push_back(closed);
        end
    endtask

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : check_results
        char_result_t want;
        bit           ok;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_chars.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual code %0h kind %0h",
                         $time, m_char_code, m_kind);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                ok = field_ok("kind", 32'(want.kind), 32'(m_kind))
                   & field_ok("char_code", 32'(want.code), 32'(m_char_code))
                   & field_ok("pattern_bits", 32'(want.bits), 32'(m_pattern_bits))
                   & field_ok("pattern_len", 32'(want.len), 32'(m_pattern_len))
                   & field_ok("end_time_ms", want.end_time, m_end_time_ms)
                   & field_ok("last", 32'(want.last), 32'(m_last));
                if (!ok) mismatches++;
            end
        end
    end

    // Result receiver; a toggle of hold_toggle starts a long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic dah, input logic [31:0] t,
                             input logic tx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid   <= 1'b0;
            s_time_ms <= $urandom();
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_is_dah    <= dah;
        s_time_ms   <= t;
        s_tx_active <= tx;
        do @(posedge aclk); while (!s_ready);
        decode_item(op, dah, t, tx);
        items_sent++;
    endtask

    // The sender stops until every expected result has been taken.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        case (idx)
            REG_ENABLE: begin
                cfg_enable = val[0];
                if (!val[0]) clear_decoder_state();
            end
            REG_TRAINING:  cfg_training  = val[0];
            REG_DIT_LEN:   cfg_dit       = val;
            REG_CHAR_MULT: cfg_char_mult = val[3:0];
            REG_WORD_MULT: cfg_word_mult = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input int dit, input int char_mult, input int word_mult);
        write_reg(REG_DIT_LEN, 16'(dit));
        write_reg(REG_CHAR_MULT, 16'(char_mult));
        write_reg(REG_WORD_MULT, 16'(word_mult));
    endtask

    task automatic key_pattern(input logic [6:0] bits, input int len);
        for (int n = 0; n < len; n++) begin
            send_item(OP_ELEMENT, (n < 7) ? bits[n % 7] : 1'($urandom_range(1)), cur_time,
                      1'($urandom_range(1)));
            cur_time = cur_time + 32'($urandom_range(3, 1));
        end
    endtask

    task automatic send_tick(input logic [31:0] silence, input logic tx);
        send_item(OP_TICK, 1'($urandom_range(1)), last_end + silence, tx);
    endtask

    function automatic logic [31:0] pick_silence();
        logic [31:0] cthr;
        logic [31:0] wthr;
        cthr = 32'(cfg_dit) * 32'(cfg_char_mult);
        wthr = 32'(cfg_dit) * 32'(cfg_word_mult);
        case ($urandom_range(2))
            0:       return (cthr == 0) ? 32'd0 : 32'($urandom_range(cthr - 1, 0));
            1:       return 32'($urandom_range((wthr > cthr) ? wthr - 1 : cthr, cthr));
            default: return ((wthr > cthr) ? wthr : cthr) + 32'($urandom_range(40));
        endcase
    endfunction

    task automatic test_default_timing();
        cur_time = 32'd1000;
        key_pattern(7'b0000010, 2);
        send_tick(32'd179, 1'b0);
        send_tick(32'd500, 1'b1);
        send_tick(32'd180, 1'b0);
        send_tick(32'd419, 1'b0);
        send_tick(32'd420, 1'b0);
        wait_idle();
    endtask

    task automatic test_pattern_limits();
        cur_time = 32'h8000_0000;
        key_pattern(7'($urandom()), 8);
        send_tick(32'd180, 1'b0);
        // Element times cross the 32-bit wrap here.
        cur_time = 32'hFFFF_FFFF;
        key_pattern(7'b0100001, 6);
        send_tick(32'd180, 1'b0);
        cur_time = 32'd0;
        key_pattern(7'b0011111, 5);
        send_tick(32'hFFFF_FFFF, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_thresholds();
        set_timing(1, 1, 1);
        key_pattern(7'b0000000, 1);
        send_tick(32'd1, 1'b0);
        wait_idle();
        set_timing(1, 0, 15);
        key_pattern(7'b0000001, 1);
        send_tick(32'd0, 1'b0);
        wait_idle();
        write_reg(REG_DIT_LEN, 16'd0);
        send_tick(32'd0, 1'b0);
        wait_idle();
        set_timing(60, 3, 7);
    endtask

    task automatic test_training_mode();
        key_pattern(7'b0000000, 1);
        send_tick(32'd180, 1'b0);
        wait_idle();
        write_reg(REG_TRAINING, 16'd1);
        key_pattern(7'b0000001, 1);
        send_tick(32'd180, 1'b0);
        send_tick(32'd420, 1'b0);
        wait_idle();
        write_reg(REG_TRAINING, 16'd0);
    endtask

    task automatic test_disable_clears();
        key_pattern(7'b0000011, 2);
        send_tick(32'd180, 1'b0);
        key_pattern(7'b0000001, 2);
        wait_idle();
        write_reg(REG_ENABLE, 16'd0);
        send_item(OP_ELEMENT, 1'b1, cur_time, 1'b0);
        send_tick(32'd1000, 1'b0);
        wait_idle();
        write_reg(REG_ENABLE, 16'd1);
        send_tick(32'd1000, 1'b0);
        wait_idle();
    endtask

    // The receiver holds off while more characters arrive than the block can buffer,
    // and the word store overflows before a full word is sent.
    task automatic test_full_word_backpressure();
        set_timing(1, 1, 15);
        hold_toggle <= ~hold_toggle;
        repeat (WORD_CAPACITY + 1) begin
            key_pattern(7'b0000000, 1);
            send_tick(32'd1, 1'b0);
        end
        send_tick(32'd15, 1'b0);
        wait_idle();
    endtask

    task automatic run_random(input int count);
        int          target;
        int          roll;
        int          e;
        int          len;
        logic [6:0]  bits;
        target = items_sent + count;
        while (items_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                          1'($urandom_range(1)));
            end else begin
                if (roll < 80) begin
                    e    = $urandom_range(ITU_ENTRIES - 1);
                    bits = code_to_bits(itu_codes[e]);
                    len  = itu_codes[e].len();
                end else begin
                    bits = 7'($urandom());
                    len  = $urandom_range(9);
                end
                key_pattern(bits, len);
                repeat ($urandom_range(3, 1))
                    send_tick(pick_silence(), ($urandom_range(99) < 15));
            end
            if ($urandom_range(99) < 4) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        reset_decoder_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 37;
        sink_idle_pct <= 75;
        test_default_timing();
        test_pattern_limits();
        test_zero_thresholds();
        test_training_mode();
        test_disable_clears();

        cur_time = $urandom();
        run_random(35);

        src_idle_pct = 75;
        sink_idle_pct <= 37;
        set_timing(1, 1, 15);
        cur_time = $urandom();
        run_random(35);

        src_idle_pct = 0;
        sink_idle_pct <= 0;
        test_full_word_backpressure();

        write_reg(REG_TRAINING, 16'd1);
        set_timing(65535, 15, 1);
        cur_time = $urandom();
        run_random(35);

        write_reg(REG_TRAINING, 16'd0);
        set_timing($urandom_range(500, 2), $urandom_range(4, 1), $urandom_range(15, 5));
        cur_time = $urandom();
        run_random(35);

        wait_idle();
        $display("Covered %0d input and %0d result transactions over %0d register writes,",
                 items_sent, results_seen, reg_writes);
        $display("including overflow, training, disable, wrap and back-pressure cases.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
